// ===== hdl/ttbpm_pkg.sv =====
// Shared package for the tap tempo estimator: field widths, reset values,
// controller state encoding and the controller/datapath handshake structs.
// No dependencies.
package ttbpm_pkg;

    localparam int          HISTORY_DEF      = 8;
    localparam int          TAP_W            = 32;
    localparam int          TIMEOUT_W        = 16;
    localparam int          TEMPO_W          = 23;
    localparam int          USED_W           = 4;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd2000;
    localparam logic [22:0] CENTI_BPM_PER_MS = 23'd6000000;
    localparam logic [22:0] TEMPO_MAX        = 23'd6000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } ttbpm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the tap, apply the gap timeout
        logic read_hist;    // read the oldest tap, form the numerator
        logic update_ring;  // write the new tap into the ring
        logic div_load;     // start the divider
        logic div_step;     // one quotient bit
        logic publish;      // load the output register
    } ttbpm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic no_tempo;     // no earlier tap or zero span
        logic div_last;     // the current step yields the last quotient bit
        logic out_free;     // output register can take a result this cycle
    } ttbpm_status_t;

endpackage

// ===== hdl/ttbpm_ctrl.sv =====
// Controller state machine of the tap tempo estimator.
// Depends on ttbpm_pkg for the state enum and the command/status structs.
module ttbpm_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  ttbpm_pkg::ttbpm_status_t status,
    output ttbpm_pkg::ttbpm_cmd_t    cmd
);
    import ttbpm_pkg::*;

    ttbpm_state_t state_reg;
    ttbpm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_hist = 1'b1;
                state_next    = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.update_ring = 1'b1;
                if (status.no_tempo)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ttbpm_datapath.sv =====
// Datapath of the tap tempo estimator: timeout register, tap ring memory,
// ring pointers, restoring divider and output register.
// Depends on ttbpm_pkg for widths, constants and the command/status structs.
module ttbpm_datapath #(
    parameter int HISTORY = ttbpm_pkg::HISTORY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ttbpm_pkg::TIMEOUT_W-1:0]     cfg_wdata,
    input  logic [ttbpm_pkg::TAP_W-1:0]         tap_time_ms,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                tempo_valid,
    output logic [ttbpm_pkg::TEMPO_W-1:0]       tempo_centi_bpm,
    output logic [ttbpm_pkg::USED_W-1:0]        intervals_used,
    input  ttbpm_pkg::ttbpm_cmd_t               cmd,
    output ttbpm_pkg::ttbpm_status_t            status
);
    import ttbpm_pkg::*;

    localparam int COUNT_W = $clog2(HISTORY + 1);
    localparam int SLOT_W  = $clog2(HISTORY);
    localparam int SUM_W   = COUNT_W + 1;
    localparam int NUM_W   = TEMPO_W + COUNT_W;
    localparam int BIT_W   = $clog2(NUM_W);

    localparam logic [COUNT_W-1:0] HIST_COUNT = COUNT_W'(HISTORY);
    localparam logic [SUM_W-1:0]   HIST_SUM   = SUM_W'(HISTORY);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(HISTORY - 1);
    localparam logic [BIT_W-1:0]   LAST_BIT   = BIT_W'(NUM_W - 1);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TAP_W-1:0]     prev_tap_reg;
    logic [TAP_W-1:0]     now_reg;
    logic [TAP_W-1:0]     rd_reg;
    logic [TAP_W-1:0]     span_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   k_reg;
    logic [SLOT_W-1:0]    oldest_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     dq_reg;
    logic [TAP_W-1:0]     rem_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic                 res_ok_reg;
    logic                 out_valid_reg;
    logic                 tempo_valid_reg;
    logic [TEMPO_W-1:0]   tempo_reg;
    logic [USED_W-1:0]    used_reg;

    logic [TAP_W-1:0]     hist_mem [HISTORY];

    logic [TAP_W-1:0]     gap;
    logic                 gap_expired;
    logic [TAP_W-1:0]     span;
    logic [SUM_W-1:0]     slot_sum;
    logic [SUM_W-1:0]     slot_wrap;
    logic                 ring_full;
    logic [SLOT_W-1:0]    wr_slot;
    logic [SLOT_W-1:0]    oldest_inc;
    logic [TAP_W:0]       trial;
    logic                 trial_ge;
    logic [TAP_W:0]       trial_diff;
    logic [TEMPO_W-1:0]   tempo_sat;

    assign gap         = tap_time_ms - prev_tap_reg;
    assign gap_expired = gap > {{(TAP_W - TIMEOUT_W){1'b0}}, timeout_reg};
    assign span        = now_reg - rd_reg;

    assign ring_full  = count_reg == HIST_COUNT;
    assign slot_sum   = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign slot_wrap  = (slot_sum >= HIST_SUM) ? slot_sum - HIST_SUM : slot_sum;
    assign wr_slot    = ring_full ? oldest_reg : slot_wrap[SLOT_W-1:0];
    assign oldest_inc = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;

    // One restoring division step: shift in the next numerator bit.
    assign trial      = {rem_reg, dq_reg[NUM_W-1]};
    assign trial_ge   = trial >= {1'b0, span_reg};
    assign trial_diff = trial - {1'b0, span_reg};

    // Saturate the quotient at the top of the tempo range.
    assign tempo_sat = (dq_reg > NUM_W'(TEMPO_MAX)) ? TEMPO_MAX : dq_reg[TEMPO_W-1:0];

    assign status.no_tempo = (k_reg == '0) || (span == '0);
    assign status.div_last = bit_reg == '0;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            prev_tap_reg <= '0;
            count_reg    <= '0;
            oldest_reg   <= '0;
            res_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                prev_tap_reg <= tap_time_ms;
                res_ok_reg   <= 1'b0;
                if (gap_expired)
                begin
                    count_reg  <= '0;
                    oldest_reg <= '0;
                end
            end
            if (cmd.update_ring)
            begin
                if (ring_full)
                begin
                    oldest_reg <= oldest_inc;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.div_load)
            begin
                res_ok_reg <= 1'b1;
            end
        end
    end

    // Tap ring, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.update_ring)
        begin
            hist_mem[wr_slot] <= now_reg;
        end
        if (cmd.read_hist)
        begin
            rd_reg <= hist_mem[oldest_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg <= tap_time_ms;
        end
        if (cmd.read_hist)
        begin
            k_reg   <= count_reg;
            num_reg <= NUM_W'(count_reg) * NUM_W'(CENTI_BPM_PER_MS);
        end
        if (cmd.div_load)
        begin
            span_reg <= span;
            dq_reg   <= num_reg;
            rem_reg  <= '0;
            bit_reg  <= LAST_BIT;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[TAP_W-1:0] : trial[TAP_W-1:0];
            dq_reg  <= {dq_reg[NUM_W-2:0], trial_ge};
            bit_reg <= bit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            tempo_valid_reg <= res_ok_reg;
            tempo_reg       <= res_ok_reg ? tempo_sat : '0;
            used_reg        <= res_ok_reg ? USED_W'(k_reg) : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tempo_valid     = tempo_valid_reg;
    assign tempo_centi_bpm = tempo_reg;
    assign intervals_used  = used_reg;

endmodule

// ===== hdl/tap_tempo_bpm_estimator.sv =====
// Top level of the tap tempo estimator: controller plus datapath.
// Depends on ttbpm_pkg, ttbpm_ctrl and ttbpm_datapath.
//
// Input channel: one item per tap, tap_time_ms from a free-running millisecond
// counter, accepted when in_valid is high and in_stall is low. Output channel:
// exactly one item per tap (tempo_valid, tempo_centi_bpm, intervals_used),
// taken when out_valid is high and out_stall is low. cfg_wdata is written into
// the gap timeout register when cfg_we is high; write it only while idle.
// A tap with a usable span runs READ, SETUP, NUM_W divider steps and a publish,
// where NUM_W = 23 + clog2(HISTORY + 1). A tap with no earlier tap or a zero
// span skips the divider and goes from SETUP straight to the publish. The
// restoring divider, one quotient bit per cycle, sets the pace: the next tap is
// taken in the cycle after publish, so a new tap waits until the last is published.
// in_stall is high from acceptance until the result enters the output register;
// that register holds the item while out_stall is high, and the next tap may be
// accepted and carried up to its publish meanwhile.
// rst_n clears the history, the previous tap time and the output valid and
// loads a 2000 ms timeout; the tap ring itself is not cleared.
module tap_tempo_bpm_estimator #(
    parameter int HISTORY = ttbpm_pkg::HISTORY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ttbpm_pkg::TIMEOUT_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ttbpm_pkg::TAP_W-1:0]         tap_time_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                tempo_valid,
    output logic [ttbpm_pkg::TEMPO_W-1:0]       tempo_centi_bpm,
    output logic [ttbpm_pkg::USED_W-1:0]        intervals_used
);
    import ttbpm_pkg::*;

    ttbpm_cmd_t    cmd;
    ttbpm_status_t status;

    // Sequence one tap at a time through read, ring update, divide, publish.
    ttbpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the ring, the divider and the output register.
    ttbpm_datapath #(
        .HISTORY (HISTORY)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .tap_time_ms     (tap_time_ms),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .tempo_valid     (tempo_valid),
        .tempo_centi_bpm (tempo_centi_bpm),
        .intervals_used  (intervals_used),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

// ===== hdl/ttbpm_checker.sv =====
// Port-level checker for the tap tempo estimator, bound to the top level.
// Depends on ttbpm_pkg for field widths and the tempo ceiling.
module ttbpm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                tempo_valid,
    input logic [ttbpm_pkg::TEMPO_W-1:0]       tempo_centi_bpm,
    input logic [ttbpm_pkg::USED_W-1:0]        intervals_used
);
    import ttbpm_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tempo_valid)
            && $stable(tempo_centi_bpm) && $stable(intervals_used))
        else $error("stalled output item changed");

    // Drop the input side after each accepted item.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while one is in work");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tempo_valid |-> tempo_centi_bpm == '0 && intervals_used == '0)
        else $error("invalid result carries nonzero fields");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tempo_valid |-> tempo_centi_bpm <= TEMPO_MAX
            && tempo_centi_bpm != '0)
        else $error("valid tempo out of range");

endmodule

bind tap_tempo_bpm_estimator ttbpm_checker u_ttbpm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tempo_valid     (tempo_valid),
    .tempo_centi_bpm (tempo_centi_bpm),
    .intervals_used  (intervals_used)
);
